// ----- hdl/pmfb_pkg.sv -----
package pmfb_pkg;

  localparam int Columns = 128;
  localparam int Pages   = 8;
  localparam int Rows    = Pages * 8;
  localparam int Depth   = Columns * Pages;
  localparam int AddrW   = $clog2(Depth);
  localparam int GrpW    = (Pages > 1) ? $clog2(Pages) : 1;

  localparam logic [7:0] XMax = 8'(Columns - 1);
  localparam logic [7:0] YMax = 8'(Rows - 1);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [GrpW-1:0]  group_t;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_RECT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    logic       re;
    addr_t      raddr;
    logic       we;
    addr_t      waddr;
    logic [7:0] wdata;
  } mem_req_t;

  // byte address of column x, page pg
  function automatic addr_t store_addr(logic [7:0] x, group_t pg);
    return addr_t'(int'(x) * Pages + int'(pg));
  endfunction

  // row group 0 is the top eight rows, held in the highest page
  function automatic group_t page_of(group_t g);
    return group_t'(Pages - 1 - int'(g));
  endfunction

endpackage

// ----- hdl/pmfb_store.sv -----
module pmfb_store (
  input  logic               clk_i,
  input  pmfb_pkg::mem_req_t mem_req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [pmfb_pkg::Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= mem_q[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pmfb_ctrl.sv -----
module pmfb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         x_start_i,
  input  logic [7:0]         y_start_i,
  input  logic [7:0]         x_end_i,
  input  logic [7:0]         y_end_i,
  input  logic               pixel_on_i,
  input  logic [2:0]         page_index_i,
  input  logic               out_free_i,
  output logic               res_push_o,
  output logic [7:0]         res_data_o,
  output pmfb_pkg::mem_req_t mem_req_o,
  input  logic [7:0]         mem_rdata_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [7:0]           x_q, x_d, x1_q, x1_d;
  pmfb_pkg::group_t     g_q, g_d, g0_q, g0_d, g1_q, g1_d;
  logic [2:0]           ylo_q, ylo_d, yhi_q, yhi_d;
  logic                 on_q, on_d;
  pmfb_pkg::addr_t      addr_q, addr_d;
  pmfb_pkg::addr_t      clr_q, clr_d;
  logic                 init_q, init_d;
  logic                 rd_sel_q, rd_sel_d;

  logic [7:0]           x_lim, y_lim, x1c, y1c;
  logic                 empty, rd_ok, last_g, last;
  pmfb_pkg::group_t     g0_in, g1_in, ng;
  logic [7:0]           nx;
  logic [2:0]           lo, hi;
  logic [7:0]           mask;

  assign in_ready_o = (state_q == S_IDLE);

  // clip the far corner; a single pixel is a one-by-one rectangle
  always_comb begin
    x_lim = (pmfb_pkg::op_e'(operation_i) == pmfb_pkg::OP_PIXEL) ? x_start_i : x_end_i;
    y_lim = (pmfb_pkg::op_e'(operation_i) == pmfb_pkg::OP_PIXEL) ? y_start_i : y_end_i;
    x1c   = (x_lim > pmfb_pkg::XMax) ? pmfb_pkg::XMax : x_lim;
    y1c   = (y_lim > pmfb_pkg::YMax) ? pmfb_pkg::YMax : y_lim;
    empty = (x_start_i > x1c) || (y_start_i > y1c);
    g0_in = pmfb_pkg::group_t'(y_start_i >> 3);
    g1_in = pmfb_pkg::group_t'(y1c >> 3);
    rd_ok = (x_start_i <= pmfb_pkg::XMax) && (5'(page_index_i) < 5'(pmfb_pkg::Pages));
  end

  // walk: row groups inside a column, then next column
  always_comb begin
    last_g = (g_q == g1_q);
    last   = last_g && (x_q == x1_q);
    nx     = last_g ? x_q + 8'd1 : x_q;
    ng     = last_g ? g0_q : g_q + pmfb_pkg::group_t'(1);
    lo     = (g_q == g0_q) ? ylo_q : 3'd0;
    hi     = (g_q == g1_q) ? yhi_q : 3'd7;
    mask   = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
  end

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    x1_d       = x1_q;
    g_d        = g_q;
    g0_d       = g0_q;
    g1_d       = g1_q;
    ylo_d      = ylo_q;
    yhi_d      = yhi_q;
    on_d       = on_q;
    addr_d     = addr_q;
    clr_d      = clr_q;
    init_d     = init_q;
    rd_sel_d   = rd_sel_q;
    mem_req_o  = '0;
    res_push_o = 1'b0;
    res_data_o = 8'h00;

    unique case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        mem_req_o.wdata = 8'h00;
        if (clr_q == pmfb_pkg::addr_t'(pmfb_pkg::Depth - 1)) begin
          rd_sel_d = 1'b0;
          state_d  = init_q ? S_IDLE : S_DONE;
          init_d   = 1'b0;
        end else begin
          clr_d = clr_q + pmfb_pkg::addr_t'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (pmfb_pkg::op_e'(operation_i))
            pmfb_pkg::OP_PIXEL, pmfb_pkg::OP_RECT: begin
              if (empty) begin
                rd_sel_d = 1'b0;
                state_d  = S_DONE;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = pmfb_pkg::store_addr(x_start_i, pmfb_pkg::page_of(g0_in));
                addr_d  = mem_req_o.raddr;
                x_d     = x_start_i;
                x1_d    = x1c;
                g_d     = g0_in;
                g0_d    = g0_in;
                g1_d    = g1_in;
                ylo_d   = y_start_i[2:0];
                yhi_d   = y1c[2:0];
                on_d    = pixel_on_i;
                state_d = S_FILL;
              end
            end
            pmfb_pkg::OP_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            pmfb_pkg::OP_READ: begin
              mem_req_o.re    = rd_ok;
              mem_req_o.raddr = pmfb_pkg::store_addr(x_start_i,
                                  pmfb_pkg::group_t'(page_index_i));
              rd_sel_d = rd_ok;
              state_d  = S_DONE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FILL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = addr_q;
        mem_req_o.wdata = on_q ? (mem_rdata_i | mask) : (mem_rdata_i & ~mask);
        if (last) begin
          rd_sel_d = 1'b0;
          if (out_free_i) begin
            res_push_o = 1'b1;
            state_d    = S_IDLE;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          // fetch the next byte while this one is written back
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = pmfb_pkg::store_addr(nx, pmfb_pkg::page_of(ng));
          addr_d = mem_req_o.raddr;
          x_d    = nx;
          g_d    = ng;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_push_o = 1'b1;
          res_data_o = rd_sel_q ? mem_rdata_i : 8'h00;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      init_q   <= 1'b1;
      rd_sel_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      init_q   <= init_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    x1_q   <= x1_d;
    g_q    <= g_d;
    g0_q   <= g0_d;
    g1_q   <= g1_d;
    ylo_q  <= ylo_d;
    yhi_q  <= yhi_d;
    on_q   <= on_d;
    addr_q <= addr_d;
  end

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.re && mem_req_o.we) |-> (mem_req_o.raddr != mem_req_o.waddr))
    else $error("read and write of the same byte in one cycle");

  a_fill_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> ($past(mem_req_o.re) && (addr_q == $past(mem_req_o.raddr))))
    else $error("write-back without a matching fetch");

  a_push_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> out_free_i)
    else $error("result pushed into an occupied output register");

  a_clear_writes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (mem_req_o.we && (mem_req_o.wdata == 8'h00) && !mem_req_o.re))
    else $error("clearing pass not writing zero");
`endif

endmodule

// ----- hdl/page_mapped_pixel_frame_buffer.sv -----
// channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------------
// in       | in_valid_i/in_ready_o | operation, x_start, y_start, x_end, y_end,
//          |                       | pixel_on, page_index
// out      | out_valid_o/out_ready_i | read_data
//
// Pixel draw and rectangle fetch and write back each page byte touched in turn;
// page read fetches one byte; clear-all writes zero to every byte.
// The single store port pair gives one fetch and one write-back a cycle.
// After reset a clearing pass zeroes the store; no transfer is taken in until
// it ends. Results sit in an output register; the next item is taken while one
// waits, and an item holds at completion until that register is free.
module page_mapped_pixel_frame_buffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] x_start_i,
  input  logic [7:0] y_start_i,
  input  logic [7:0] x_end_i,
  input  logic [7:0] y_end_i,
  input  logic       pixel_on_i,
  input  logic [2:0] page_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o
);

  pmfb_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rdata;
  logic               out_free, res_push;
  logic [7:0]         res_data;
  logic               out_valid_q;
  logic [7:0]         read_data_q;

  assign out_free = !out_valid_q || out_ready_i;

  pmfb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .pixel_on_i   (pixel_on_i),
    .page_index_i (page_index_i),
    .out_free_i   (out_free),
    .res_push_o   (res_push),
    .res_data_o   (res_data),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  pmfb_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      read_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

endmodule
